>>> hw/rtl/etm_pkg.sv
// Shared types, constants and arithmetic helpers for the model matrix unit.
package etm_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int TRIG_ITER_DEF = 18;
  localparam int ATAN_ENTRIES  = 30;
  localparam int QUEUE_DEPTH   = 4;

  typedef logic signed [31:0] etm_word_t;
  typedef logic signed [35:0] etm_trig_t;

  localparam etm_trig_t   CORDIC_GAIN = 36'sd652032874;
  localparam logic [30:0] DEG_TO_RAD  = 31'd1199381129;

  typedef struct packed {
    etm_word_t pos_x;
    etm_word_t pos_y;
    etm_word_t pos_z;
    etm_word_t angle_x;
    etm_word_t angle_y;
    etm_word_t angle_z;
    etm_word_t scale_x;
    etm_word_t scale_y;
    etm_word_t scale_z;
  } etm_in_t;

  typedef struct packed {
    etm_word_t m00;
    etm_word_t m01;
    etm_word_t m02;
    etm_word_t m03;
    etm_word_t m10;
    etm_word_t m11;
    etm_word_t m12;
    etm_word_t m13;
    etm_word_t m20;
    etm_word_t m21;
    etm_word_t m22;
    etm_word_t m23;
  } etm_out_t;

  // Reduced angle: quadrant plus residual angle in radians, Q2.30
  typedef struct packed {
    logic [1:0] quad_x;
    logic [1:0] quad_y;
    logic [1:0] quad_z;
    etm_trig_t  ang_x;
    etm_trig_t  ang_y;
    etm_trig_t  ang_z;
    etm_word_t  pos_x;
    etm_word_t  pos_y;
    etm_word_t  pos_z;
    etm_word_t  scale_x;
    etm_word_t  scale_y;
    etm_word_t  scale_z;
  } etm_work_t;

  typedef struct packed {
    logic full;
    logic empty;
  } etm_q_status_t;

  // atan(2^-i) in Q2.30
  function automatic etm_trig_t atan_q30(input logic [4:0] idx);
    etm_trig_t v;
    case (idx)
      5'd0:  v = 36'sd843314857;
      5'd1:  v = 36'sd497837829;
      5'd2:  v = 36'sd263043837;
      5'd3:  v = 36'sd133525159;
      5'd4:  v = 36'sd67021687;
      5'd5:  v = 36'sd33543516;
      5'd6:  v = 36'sd16775851;
      5'd7:  v = 36'sd8388437;
      5'd8:  v = 36'sd4194283;
      5'd9:  v = 36'sd2097149;
      5'd10: v = 36'sd1048576;
      5'd11: v = 36'sd524288;
      5'd12: v = 36'sd262144;
      5'd13: v = 36'sd131072;
      5'd14: v = 36'sd65536;
      5'd15: v = 36'sd32768;
      5'd16: v = 36'sd16384;
      5'd17: v = 36'sd8192;
      5'd18: v = 36'sd4096;
      5'd19: v = 36'sd2048;
      5'd20: v = 36'sd1024;
      5'd21: v = 36'sd512;
      5'd22: v = 36'sd256;
      5'd23: v = 36'sd128;
      5'd24: v = 36'sd64;
      5'd25: v = 36'sd32;
      5'd26: v = 36'sd16;
      5'd27: v = 36'sd8;
      5'd28: v = 36'sd4;
      5'd29: v = 36'sd2;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Q2.30 product, round half up
  function automatic etm_trig_t mul_q30(input etm_trig_t a, input etm_trig_t b);
    logic signed [71:0] p;
    p = a * b + 72'sd536870912;
    return etm_trig_t'(p >>> 30);
  endfunction

  // Round a Q2.30-by-word product and clamp to the signed 32-bit range
  function automatic etm_word_t sat_q30(input logic signed [67:0] p);
    logic signed [67:0] v;
    etm_word_t r;
    v = (p + 68'sd536870912) >>> 30;
    if (v > 68'sd2147483647) r = 32'sh7fff_ffff;
    else if (v < -68'sd2147483648) r = 32'sh8000_0000;
    else r = etm_word_t'(v);
    return r;
  endfunction

endpackage

>>> hw/rtl/etm_front.sv
// Front end: takes items, reduces each angle to quadrant and radian residual.
module etm_front import etm_pkg::*; #(
  parameter int FRAC_BITS = FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  etm_in_t       in_data,
  output logic          f_valid,
  output etm_work_t     f_data,
  input  etm_q_status_t q_status
);

  localparam logic [40:0] PERIOD   = 41'(360) << FRAC_BITS;
  localparam logic [40:0] QUARTER  = 41'(90) << FRAC_BITS;
  localparam logic [40:0] H1       = QUARTER >> 1;
  localparam logic [40:0] H3       = H1 * 3;
  localparam logic [40:0] H5       = H1 * 5;
  localparam logic [40:0] H7       = H1 * 7;
  localparam logic [40:0] BIAS     = (41'd1 << 31) % PERIOD;
  localparam int          RED_RAW  = 33 - $clog2(PERIOD);
  localparam int          RED_STEPS = (RED_RAW < 1) ? 1 : RED_RAW;
  localparam int          RZ_SHIFT = FRAC_BITS + 6;

  logic               adv;
  logic [RED_STEPS:0] red_v_r;
  etm_in_t            item_r [0:RED_STEPS];
  logic [32:0]        res_r  [0:RED_STEPS][0:2];
  logic               fix_v_r;
  etm_in_t            fix_item_r;
  logic [32:0]        rem_r  [0:2];
  logic               qd_v_r;
  etm_in_t            qd_item_r;
  logic [32:0]        mag_r  [0:2];
  logic               neg_r  [0:2];
  logic [1:0]         quad_r [0:2];
  logic               f_valid_r;
  etm_work_t          f_data_r;

  logic [31:0]        ang_in [0:2];
  logic [2:0]         cnt    [0:2];
  logic [40:0]        base   [0:2];
  logic [61:0]        zp     [0:2];
  etm_trig_t          zs     [0:2];

  // hold everything while the queue refuses the finished item
  assign adv      = !(f_valid_r && q_status.full);
  assign in_stall = !adv;
  assign f_valid  = f_valid_r;
  assign f_data   = f_data_r;

  assign ang_in[0] = in_data.angle_x;
  assign ang_in[1] = in_data.angle_y;
  assign ang_in[2] = in_data.angle_z;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_v_r   <= '0;
      fix_v_r   <= 1'b0;
      qd_v_r    <= 1'b0;
      f_valid_r <= 1'b0;
    end else if (adv) begin
      red_v_r   <= {red_v_r[RED_STEPS-1:0], in_valid};
      fix_v_r   <= red_v_r[RED_STEPS];
      qd_v_r    <= fix_v_r;
      f_valid_r <= qd_v_r;
    end
  end

  // offset to unsigned so the modulo runs on a plain magnitude
  always_ff @(posedge clk) begin
    if (adv) begin
      item_r[0] <= in_data;
      for (int a = 0; a < 3; a++) begin
        res_r[0][a] <= {1'b0, ang_in[a] ^ 32'h8000_0000};
      end
    end
  end

  for (genvar k = 0; k < RED_STEPS; k++) begin : g_red
    localparam logic [40:0] SUB = PERIOD << (RED_STEPS - 1 - k);
    always_ff @(posedge clk) begin
      if (adv) begin
        item_r[k+1] <= item_r[k];
        for (int a = 0; a < 3; a++) begin
          if ({8'd0, res_r[k][a]} >= SUB) res_r[k+1][a] <= res_r[k][a] - SUB[32:0];
          else res_r[k+1][a] <= res_r[k][a];
        end
      end
    end
  end

  always_comb begin
    for (int a = 0; a < 3; a++) begin
      cnt[a] = 3'({8'd0, rem_r[a]} >= H1) + 3'({8'd0, rem_r[a]} >= H3)
             + 3'({8'd0, rem_r[a]} >= H5) + 3'({8'd0, rem_r[a]} >= H7);
      case (cnt[a])
        3'd0:    base[a] = '0;
        3'd1:    base[a] = QUARTER;
        3'd2:    base[a] = QUARTER * 2;
        3'd3:    base[a] = QUARTER * 3;
        default: base[a] = QUARTER * 4;
      endcase
      zp[a] = mag_r[a][30:0] * DEG_TO_RAD;
      zs[a] = etm_trig_t'(zp[a] >> RZ_SHIFT);
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fix_item_r <= item_r[RED_STEPS];
      for (int a = 0; a < 3; a++) begin
        if ({8'd0, res_r[RED_STEPS][a]} >= BIAS)
          rem_r[a] <= 33'({8'd0, res_r[RED_STEPS][a]} - BIAS);
        else
          rem_r[a] <= 33'({8'd0, res_r[RED_STEPS][a]} + PERIOD - BIAS);
      end
      qd_item_r <= fix_item_r;
      for (int a = 0; a < 3; a++) begin
        quad_r[a] <= cnt[a][1:0];
        neg_r[a]  <= ({8'd0, rem_r[a]} < base[a]);
        if ({8'd0, rem_r[a]} < base[a]) mag_r[a] <= 33'(base[a] - {8'd0, rem_r[a]});
        else mag_r[a] <= 33'({8'd0, rem_r[a]} - base[a]);
      end
      f_data_r.quad_x  <= quad_r[0];
      f_data_r.quad_y  <= quad_r[1];
      f_data_r.quad_z  <= quad_r[2];
      f_data_r.ang_x   <= neg_r[0] ? -zs[0] : zs[0];
      f_data_r.ang_y   <= neg_r[1] ? -zs[1] : zs[1];
      f_data_r.ang_z   <= neg_r[2] ? -zs[2] : zs[2];
      f_data_r.pos_x   <= qd_item_r.pos_x;
      f_data_r.pos_y   <= qd_item_r.pos_y;
      f_data_r.pos_z   <= qd_item_r.pos_z;
      f_data_r.scale_x <= qd_item_r.scale_x;
      f_data_r.scale_y <= qd_item_r.scale_y;
      f_data_r.scale_z <= qd_item_r.scale_z;
    end
  end

endmodule

>>> hw/rtl/etm_queue.sv
// Short queue between front end and matrix back end.
module etm_queue import etm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  etm_work_t     push_data,
  input  logic          pop,
  output etm_work_t     head,
  output etm_q_status_t status
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  etm_work_t   slot_r [0:QUEUE_DEPTH-1];
  logic [PW-1:0] wr_ptr_r;
  logic [PW-1:0] rd_ptr_r;
  logic [PW:0]   cnt_r;
  logic          do_push;
  logic          do_pop;

  assign status.full  = (cnt_r == (PW+1)'(QUEUE_DEPTH));
  assign status.empty = (cnt_r == '0);
  assign do_push      = push && !status.full;
  assign do_pop       = pop && !status.empty;
  assign head         = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (do_push) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (do_pop)  rd_ptr_r <= rd_ptr_r + 1'b1;
      case ({do_push, do_pop})
        2'b10:   cnt_r <= cnt_r + 1'b1;
        2'b01:   cnt_r <= cnt_r - 1'b1;
        default: cnt_r <= cnt_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) slot_r[wr_ptr_r] <= push_data;
  end

endmodule

>>> hw/rtl/etm_back.sv
// Back end: CORDIC sin/cos pipeline, rotation products, scaling and output register.
module etm_back import etm_pkg::*; #(
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  etm_work_t     head,
  input  etm_q_status_t q_status,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output etm_out_t      out_data
);

  localparam int N = (TRIG_ITERATIONS > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITERATIONS;

  logic       adv;
  logic [N:0] cv_r;
  etm_work_t  wk_r [0:N];
  etm_trig_t  x_r  [0:N][0:2];
  etm_trig_t  y_r  [0:N][0:2];
  etm_trig_t  z_r  [0:N][0:2];

  logic       tv_r;
  etm_work_t  tw_r;
  etm_trig_t  c_r [0:2];
  etm_trig_t  s_r [0:2];

  logic       p1v_r;
  etm_work_t  p1w_r;
  etm_trig_t  sxsy_r, cxsy_r, cz1_r, sz1_r;
  etm_trig_t  r00_r, r01_r, r02_r, r12_r, r22_r;
  etm_trig_t  cxsz_r, cxcz_r, sxsz_r, sxcz_r;

  logic       p2v_r;
  etm_work_t  p2w_r;
  etm_trig_t  rot_r [0:2][0:2];

  logic       s1v_r;
  etm_work_t  s1w_r;
  logic signed [67:0] prod_r [0:2][0:2];

  logic       ov_r;
  etm_out_t   od_r;

  logic [1:0] qsel [0:2];

  // the whole back end freezes while the output transfer is refused
  assign adv       = !ov_r || !out_stall;
  assign pop       = adv && !q_status.empty;
  assign out_valid = ov_r;
  assign out_data  = od_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cv_r  <= '0;
      tv_r  <= 1'b0;
      p1v_r <= 1'b0;
      p2v_r <= 1'b0;
      s1v_r <= 1'b0;
      ov_r  <= 1'b0;
    end else if (adv) begin
      cv_r  <= {cv_r[N-1:0], !q_status.empty};
      tv_r  <= cv_r[N];
      p1v_r <= tv_r;
      p2v_r <= p1v_r;
      s1v_r <= p2v_r;
      ov_r  <= s1v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      wk_r[0] <= head;
      for (int a = 0; a < 3; a++) begin
        x_r[0][a] <= CORDIC_GAIN;
        y_r[0][a] <= '0;
      end
      z_r[0][0] <= head.ang_x;
      z_r[0][1] <= head.ang_y;
      z_r[0][2] <= head.ang_z;
    end
  end

  for (genvar i = 0; i < N; i++) begin : g_cordic
    always_ff @(posedge clk) begin
      if (adv) begin
        wk_r[i+1] <= wk_r[i];
        for (int a = 0; a < 3; a++) begin
          if (z_r[i][a] >= 0) begin
            x_r[i+1][a] <= x_r[i][a] - (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] + (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] - atan_q30(5'(i));
          end else begin
            x_r[i+1][a] <= x_r[i][a] + (y_r[i][a] >>> i);
            y_r[i+1][a] <= y_r[i][a] - (x_r[i][a] >>> i);
            z_r[i+1][a] <= z_r[i][a] + atan_q30(5'(i));
          end
        end
      end
    end
  end

  assign qsel[0] = wk_r[N].quad_x;
  assign qsel[1] = wk_r[N].quad_y;
  assign qsel[2] = wk_r[N].quad_z;

  always_ff @(posedge clk) begin
    if (adv) begin
      tw_r <= wk_r[N];
      for (int a = 0; a < 3; a++) begin
        case (qsel[a])
          2'd0: begin c_r[a] <= x_r[N][a];  s_r[a] <= y_r[N][a];  end
          2'd1: begin c_r[a] <= -y_r[N][a]; s_r[a] <= x_r[N][a];  end
          2'd2: begin c_r[a] <= -x_r[N][a]; s_r[a] <= -y_r[N][a]; end
          default: begin c_r[a] <= y_r[N][a]; s_r[a] <= -x_r[N][a]; end
        endcase
      end

      p1w_r  <= tw_r;
      sxsy_r <= mul_q30(s_r[0], s_r[1]);
      cxsy_r <= mul_q30(c_r[0], s_r[1]);
      cz1_r  <= c_r[2];
      sz1_r  <= s_r[2];
      r00_r  <= mul_q30(c_r[1], c_r[2]);
      r01_r  <= -mul_q30(c_r[1], s_r[2]);
      r02_r  <= s_r[1];
      r12_r  <= -mul_q30(s_r[0], c_r[1]);
      r22_r  <= mul_q30(c_r[0], c_r[1]);
      cxsz_r <= mul_q30(c_r[0], s_r[2]);
      cxcz_r <= mul_q30(c_r[0], c_r[2]);
      sxsz_r <= mul_q30(s_r[0], s_r[2]);
      sxcz_r <= mul_q30(s_r[0], c_r[2]);

      p2w_r       <= p1w_r;
      rot_r[0][0] <= r00_r;
      rot_r[0][1] <= r01_r;
      rot_r[0][2] <= r02_r;
      rot_r[1][0] <= mul_q30(sxsy_r, cz1_r) + cxsz_r;
      rot_r[1][1] <= cxcz_r - mul_q30(sxsy_r, sz1_r);
      rot_r[1][2] <= r12_r;
      rot_r[2][0] <= sxsz_r - mul_q30(cxsy_r, cz1_r);
      rot_r[2][1] <= mul_q30(cxsy_r, sz1_r) + sxcz_r;
      rot_r[2][2] <= r22_r;

      s1w_r <= p2w_r;
      for (int j = 0; j < 3; j++) begin
        prod_r[0][j] <= rot_r[0][j] * p2w_r.scale_x;
        prod_r[1][j] <= rot_r[1][j] * p2w_r.scale_y;
        prod_r[2][j] <= rot_r[2][j] * p2w_r.scale_z;
      end

      od_r.m00 <= sat_q30(prod_r[0][0]);
      od_r.m01 <= sat_q30(prod_r[0][1]);
      od_r.m02 <= sat_q30(prod_r[0][2]);
      od_r.m03 <= s1w_r.pos_x;
      od_r.m10 <= sat_q30(prod_r[1][0]);
      od_r.m11 <= sat_q30(prod_r[1][1]);
      od_r.m12 <= sat_q30(prod_r[1][2]);
      od_r.m13 <= s1w_r.pos_y;
      od_r.m20 <= sat_q30(prod_r[2][0]);
      od_r.m21 <= sat_q30(prod_r[2][1]);
      od_r.m22 <= sat_q30(prod_r[2][2]);
      od_r.m23 <= s1w_r.pos_z;
    end
  end

endmodule

>>> hw/rtl/euler_trs_model_matrix_unit.sv
// Top level of the model matrix unit: front end, queue and back end.
// Takes one object transform (position, XYZ Euler angles in degrees, scale, all
// signed Q16.16) per clock while in_stall is low and returns the top three rows of
// T*S*Rx*Ry*Rz, one result per clock while out_stall is low. The front end has
// one capture stage, one compare-subtract stage per bit of the modulo-360
// reduction, then bias fix, quadrant pick and radian multiply stages. Each item
// is then registered in the queue, and in the back end each CORDIC step is its
// own stage. A stalled output freezes the back end; the queue then fills and the
// front end stalls.
module euler_trs_model_matrix_unit import etm_pkg::*; #(
  parameter int FRAC_BITS       = FRAC_BITS_DEF,
  parameter int TRIG_ITERATIONS = TRIG_ITER_DEF
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  input  etm_in_t  in_data,
  output logic     out_valid,
  input  logic     out_stall,
  output etm_out_t out_data
);

  logic          f_valid;
  etm_work_t     f_data;
  etm_work_t     q_head;
  etm_q_status_t q_status;
  logic          q_pop;

  etm_front #(.FRAC_BITS(FRAC_BITS)) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .f_valid  (f_valid),
    .f_data   (f_data),
    .q_status (q_status)
  );

  etm_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (f_valid),
    .push_data (f_data),
    .pop       (q_pop),
    .head      (q_head),
    .status    (q_status)
  );

  etm_back #(.TRIG_ITERATIONS(TRIG_ITERATIONS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (q_head),
    .q_status  (q_status),
    .pop       (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data)
  );

  a_q_flags: assert property (@(posedge clk) disable iff (!rst_n)
    !(q_status.full && q_status.empty))
    else $error("queue full and empty at once");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (f_valid && q_status.full))
    else $error("input stalled without a blocked front end");

  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (f_valid && q_status.full) |=> (f_valid && $stable(f_data)))
    else $error("blocked front-end item lost or changed");

endmodule

>>> verif/etm_checker.sv
// Checker for the model matrix unit: predicts each result and compares it.
module etm_checker import etm_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_stall,
  input  etm_in_t  in_data,
  input  logic     out_valid,
  input  logic     out_stall,
  input  etm_out_t out_data,
  output int       fail_count,
  output int       pending
);

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int STEPS = (TRIG_ITER_DEF > ATAN_ENTRIES) ? ATAN_ENTRIES : TRIG_ITER_DEF;

  etm_out_t matrix_q[$];

  function automatic longint shr_arith(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint q30_mul(longint a, longint b);
    return (a * b + 64'sd536870912) >>> 30;
  endfunction

  function automatic etm_word_t clamp32(longint v);
    if (v > 64'sd2147483647) return 32'sh7fff_ffff;
    if (v < -64'sd2147483648) return 32'sh8000_0000;
    return etm_word_t'(v);
  endfunction

  function automatic longint atan_entry(int i);
    longint tbl [30] = '{843314857, 497837829, 263043837, 133525159, 67021687,
      33543516, 16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144,
      131072, 65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64,
      32, 16, 8, 4, 2};
    return tbl[i];
  endfunction

  function automatic void angle_trig(input etm_word_t ang, output longint c,
                                     output longint s);
    longint period, quarter, rem, q, r, m, z, x, y, dx, dy;
    period = 64'sd360 <<< FRAC;
    quarter = 64'sd90 <<< FRAC;
    rem = longint'(ang) % period;
    if (rem < 0) rem += period;
    q = rem / quarter;
    r = rem - q * quarter;
    if (2 * r >= quarter) begin
      r -= quarter;
      q++;
    end
    q &= 3;
    m = (r < 0) ? -r : r;
    z = (m * 64'sd1199381129) >>> (FRAC + 6);
    if (r < 0) z = -z;
    x = 652032874;
    y = 0;
    for (int i = 0; i < STEPS; i++) begin
      dx = shr_arith(y, i);
      dy = shr_arith(x, i);
      if (z >= 0) begin
        x -= dx; y += dy; z -= atan_entry(i);
      end else begin
        x += dx; y -= dy; z += atan_entry(i);
      end
    end
    case (q)
      0: begin c = x; s = y; end
      1: begin c = -y; s = x; end
      2: begin c = -x; s = -y; end
      default: begin c = y; s = -x; end
    endcase
  endfunction

  function automatic etm_out_t model_matrix(etm_in_t t);
    longint cx, sx, cy, sy, cz, sz, sxsy, cxsy;
    longint rot [3][3];
    longint scl [3];
    etm_out_t m;
    angle_trig(t.angle_x, cx, sx);
    angle_trig(t.angle_y, cy, sy);
    angle_trig(t.angle_z, cz, sz);
    sxsy = q30_mul(sx, sy);
    cxsy = q30_mul(cx, sy);
    rot[0][0] = q30_mul(cy, cz);
    rot[0][1] = -q30_mul(cy, sz);
    rot[0][2] = sy;
    rot[1][0] = q30_mul(sxsy, cz) + q30_mul(cx, sz);
    rot[1][1] = -q30_mul(sxsy, sz) + q30_mul(cx, cz);
    rot[1][2] = -q30_mul(sx, cy);
    rot[2][0] = -q30_mul(cxsy, cz) + q30_mul(sx, sz);
    rot[2][1] = q30_mul(cxsy, sz) + q30_mul(sx, cz);
    rot[2][2] = q30_mul(cx, cy);
    scl[0] = t.scale_x;
    scl[1] = t.scale_y;
    scl[2] = t.scale_z;
    m.m00 = clamp32(q30_mul(rot[0][0], scl[0]));
    m.m01 = clamp32(q30_mul(rot[0][1], scl[0]));
    m.m02 = clamp32(q30_mul(rot[0][2], scl[0]));
    m.m03 = t.pos_x;
    m.m10 = clamp32(q30_mul(rot[1][0], scl[1]));
    m.m11 = clamp32(q30_mul(rot[1][1], scl[1]));
    m.m12 = clamp32(q30_mul(rot[1][2], scl[1]));
    m.m13 = t.pos_y;
    m.m20 = clamp32(q30_mul(rot[2][0], scl[2]));
    m.m21 = clamp32(q30_mul(rot[2][1], scl[2]));
    m.m22 = clamp32(q30_mul(rot[2][2], scl[2]));
    m.m23 = t.pos_z;
    return m;
  endfunction

  task automatic check_word(string name, etm_word_t exp_v, etm_word_t act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0d, got %0d", name, exp_v, act_v);
      fail_count++;
    end
  endtask

  initial fail_count = 0;
  assign pending = matrix_q.size();

  always @(posedge clk) begin
    etm_out_t e;
    if (rst_n && in_valid && !in_stall) matrix_q.push_back(model_matrix(in_data));
    if (rst_n && out_valid && !out_stall) begin
      if (matrix_q.size() == 0) begin
        $error("result transfer with nothing expected");
        fail_count++;
      end else begin
        e = matrix_q.pop_front();
        check_word("m00", e.m00, out_data.m00);
        check_word("m01", e.m01, out_data.m01);
        check_word("m02", e.m02, out_data.m02);
        check_word("m03", e.m03, out_data.m03);
        check_word("m10", e.m10, out_data.m10);
        check_word("m11", e.m11, out_data.m11);
        check_word("m12", e.m12, out_data.m12);
        check_word("m13", e.m13, out_data.m13);
        check_word("m20", e.m20, out_data.m20);
        check_word("m21", e.m21, out_data.m21);
        check_word("m22", e.m22, out_data.m22);
        check_word("m23", e.m23, out_data.m23);
      end
    end
  end

endmodule

>>> verif/tb_top.sv
// Testbench top for the model matrix unit: stimulus, stalls and verdict.
module tb_top import etm_pkg::*; ();

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  etm_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  etm_out_t out_data;
  int       fail_count;
  int       pending;
  int       cycle_count = 0;
  bit       hold_out = 1'b0;
  bit       busy_stall = 1'b0;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  euler_trs_model_matrix_unit dut (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data)
  );

  etm_checker chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .in_data(in_data), .out_valid(out_valid), .out_stall(out_stall),
    .out_data(out_data), .fail_count(fail_count), .pending(pending)
  );

  function automatic int gap_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 60);
    if ($urandom_range(0, 2) == 0) return $urandom_range(1, 3);
    return 0;
  endfunction

  function automatic etm_word_t rand_word();
    case ($urandom_range(0, 5))
      0: return etm_word_t'($urandom);
      1: return 32'sh7fff_ffff - etm_word_t'($urandom_range(0, 3));
      2: return 32'sh8000_0000 + etm_word_t'($urandom_range(0, 3));
      default: return etm_word_t'($signed($urandom_range(0, 2000000)) - 1000000) <<< 4;
    endcase
  endfunction

  function automatic etm_word_t rand_angle();
    case ($urandom_range(0, 4))
      0: return etm_word_t'($urandom);
      1: return etm_word_t'($signed($urandom_range(0, 1440)) - 720) <<< 16;
      2: return (etm_word_t'($urandom_range(0, 8)) * 45 <<< 16)
                + etm_word_t'($urandom_range(0, 2)) - 1;
      default: return etm_word_t'($signed($urandom_range(0, 47185920)) - 23592960);
    endcase
  endfunction

  function automatic etm_word_t rand_scale();
    case ($urandom_range(0, 7))
      0: return '0;
      1: return etm_word_t'($urandom);
      default: return etm_word_t'($signed($urandom_range(0, 655360)) - 327680);
    endcase
  endfunction

  task automatic send(etm_in_t t);
    in_data <= t;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_in(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  task automatic send_item(etm_in_t t, bit allow_gap);
    int g;
    send(t);
    g = allow_gap ? gap_len() : 0;
    if (g > 0) idle_in(g);
  endtask

  function automatic etm_in_t make_item(etm_word_t ax, etm_word_t ay, etm_word_t az,
                                        etm_word_t sc);
    etm_in_t t;
    t.pos_x = rand_word();
    t.pos_y = rand_word();
    t.pos_z = rand_word();
    t.angle_x = ax;
    t.angle_y = ay;
    t.angle_z = az;
    t.scale_x = sc;
    t.scale_y = sc;
    t.scale_z = sc;
    return t;
  endfunction

  // receiver stalls: random gaps, or a long hold-off on request
  always @(negedge clk) begin
    if (hold_out) out_stall <= 1'b1;
    else if (busy_stall) out_stall <= ($urandom_range(0, 3) == 0);
    else out_stall <= 1'b0;
  end

  initial begin
    int n;
    busy_stall = 1'b1;
    forever begin
      n = $urandom_range(50, 400);
      repeat (n) @(negedge clk);
      busy_stall = ~busy_stall;
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    etm_in_t t;
    repeat (11) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // extremes of every field, translation and scale
    t = {9{32'sh7fff_ffff}};
    send_item(t, 1'b0);
    t = {9{32'sh8000_0000}};
    send_item(t, 1'b0);
    t = '0;
    send_item(t, 1'b0);
    t = {9{32'sh0000_ffff}};
    send_item(t, 1'b0);
    // quadrant boundaries and rounding edges of the reduction
    for (int k = -4; k <= 8; k++) begin
      t = make_item(etm_word_t'(k * 45) <<< 16, etm_word_t'(k * 90) <<< 16,
                    (etm_word_t'(k * 45) <<< 16) - 1, 32'sh0001_0000);
      send_item(t, 1'b0);
    end
    // zero scale row, large scale saturation
    t = make_item(32'sh001e_0000, 32'sh002d_0000, 32'sh003c_0000, 32'sh7fff_ffff);
    t.scale_y = '0;
    send_item(t, 1'b0);
    t = make_item(32'sh001e_0000, 32'sh002d_0000, 32'sh003c_0000, 32'sh8000_0000);
    send_item(t, 1'b0);
    t = make_item(32'sh8000_0000, 32'sh7fff_ffff, 32'sh0000_0000, 32'sh4000_0000);
    send_item(t, 1'b0);
    // back up the output while the input keeps offering
    hold_out = 1'b1;
    fork
      begin
        repeat (150) @(negedge clk);
        hold_out = 1'b0;
      end
      for (int k = 0; k < 80; k++) begin
        t = make_item(rand_angle(), rand_angle(), rand_angle(), rand_scale());
        send_item(t, 1'b0);
      end
    join
    // drain completely before the random part
    idle_in(0);
    while (pending != 0) @(negedge clk);
    for (int k = 0; k < 1500; k++) begin
      t = make_item(rand_angle(), rand_angle(), rand_angle(), rand_scale());
      t.scale_x = rand_scale();
      t.scale_z = rand_scale();
      send_item(t, 1'b1);
    end
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (60) @(negedge clk);
    if (fail_count == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
